// ===== rtl/core/cmdp_pkg.sv =====
package cmdp_pkg;

  // command opcodes (top byte of the first word)
  localparam logic [7:0] OP_BRANCH    = 8'hDE;
  localparam logic [7:0] OP_TEXIMG    = 8'hFD;
  localparam logic [7:0] OP_END       = 8'hDF;
  localparam logic [7:0] OP_VTX       = 8'h01;
  localparam logic [7:0] OP_NEST_HASH = 8'h31;
  localparam logic [7:0] OP_VTX_HASH  = 8'h32;
  localparam logic [7:0] OP_TEX_HASH  = 8'h20;
  localparam logic [7:0] OP_CULL      = 8'h3D;
  localparam logic [7:0] CULL_SEG     = 8'h0C;

  localparam logic [31:0] PUSH_BIT = 32'h0001_0000;
  localparam logic [31:0] LOW24    = 32'h00FF_FFFF;

  // cull list indices that are accepted
  localparam logic [23:0] CULL_IDX_A = 24'd0;
  localparam logic [23:0] CULL_IDX_B = 24'd2;

  // opcodes of commands that span two transactions
  localparam int unsigned NumTwoWord = 10;
  localparam logic [7:0] TWO_WORD_OPS [NumTwoWord] = '{
    8'h20, 8'h24, 8'h25, 8'h27, 8'h31, 8'h32, 8'h33, 8'h35, 8'h36, 8'h42
  };

  localparam int unsigned VertexBytesDefault = 16;
  localparam int unsigned QueueDepthDefault  = 4;

  typedef enum logic [1:0] {
    ST_SCAN = 2'd0,
    ST_END  = 2'd1,
    ST_BAD  = 2'd2
  } list_state_e;

  typedef struct packed {
    logic [31:0] unresolved;
    logic [31:0] nested;
    logic [31:0] texture;
    logic [31:0] vertex;
    logic [31:0] cull;
  } totals_t;

  // one queue entry: the results caused by one accepted transaction
  typedef struct packed {
    logic        two_res;
    logic [31:0] r0_high;
    logic [31:0] r0_low;
    logic [31:0] r1_high;
    logic [31:0] r1_low;
    list_state_e status;
    totals_t     totals;
  } entry_t;

  function automatic logic is_two_word(input logic [7:0] op);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumTwoWord; k++) begin
      if (op == TWO_WORD_OPS[k]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic bump);
    return (bump && (v != '1)) ? v + 32'd1 : v;
  endfunction

endpackage

// ===== rtl/core/cmdp_intf.sv =====
interface cmdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_high;
  logic [31:0] word_low;
  logic        list_last;
  logic [31:0] resolved_address;
  logic [31:0] resolved_bytes;

  modport source (
    output valid, word_high, word_low, list_last, resolved_address, resolved_bytes,
    input  ready
  );
  modport sink (
    input  valid, word_high, word_low, list_last, resolved_address, resolved_bytes,
    output ready
  );
endinterface

interface cmdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_high;
  logic [31:0] out_low;
  logic        run_last;
  logic [1:0]  status;
  logic [31:0] unresolved_count;
  logic [31:0] nested_count;
  logic [31:0] texture_count;
  logic [31:0] vertex_count;
  logic [31:0] cull_count;

  modport source (
    output valid, out_high, out_low, run_last, status, unresolved_count, nested_count,
           texture_count, vertex_count, cull_count,
    input  ready
  );
  modport sink (
    input  valid, out_high, out_low, run_last, status, unresolved_count, nested_count,
           texture_count, vertex_count, cull_count,
    output ready
  );
endinterface

// ===== rtl/core/cmdp_front.sv =====
module cmdp_front import cmdp_pkg::*; #(
  parameter int unsigned VERTEX_BYTES = VertexBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmdp_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output entry_t        entry_o
);

  localparam int unsigned ProdW = 8 + $clog2(VERTEX_BYTES + 1);

  list_state_e state_q, state_d;
  logic        held_valid_q, held_valid_d;
  logic [31:0] held_high_q, held_low_q;
  totals_t     tot_q, tot_d;

  logic        act;
  logic [7:0]  op, held_op;
  logic        is_cull, cull_idx_ok, held_is_hash, vtx_too_many;
  logic [ProdW-1:0] vtx_need;
  logic        held_load, end_hit, bad_hit;
  logic        b_unres, b_nest, b_tex, b_vtx, b_cull;

  assign in_i.ready = !full_i;
  assign act        = in_i.valid && in_i.ready && (state_q == ST_SCAN);

  assign op       = in_i.word_high[31:24];
  assign held_op  = held_high_q[31:24];
  assign is_cull  = (op == OP_CULL) && (in_i.word_low[31:24] == CULL_SEG);
  assign cull_idx_ok = (in_i.word_low[23:0] == CULL_IDX_A) ||
                       (in_i.word_low[23:0] == CULL_IDX_B);
  assign held_is_hash = (held_op == OP_NEST_HASH) || (held_op == OP_TEX_HASH) ||
                        (held_op == OP_VTX_HASH);
  // count > bytes / VERTEX_BYTES  <=>  bytes < count * VERTEX_BYTES
  assign vtx_need     = ProdW'(held_high_q[19:12]) * ProdW'(VERTEX_BYTES);
  assign vtx_too_many = in_i.resolved_bytes < 32'(vtx_need);

  // results and side effects
  always_comb begin
    push_o          = 1'b0;
    held_load       = 1'b0;
    held_valid_d    = held_valid_q;
    end_hit         = 1'b0;
    bad_hit         = 1'b0;
    b_unres         = 1'b0;
    b_nest          = 1'b0;
    b_tex           = 1'b0;
    b_vtx           = 1'b0;
    b_cull          = 1'b0;
    entry_o.two_res = 1'b0;
    entry_o.r0_high = in_i.word_high;
    entry_o.r0_low  = in_i.word_low;
    entry_o.r1_high = in_i.word_high;
    entry_o.r1_low  = in_i.word_low;
    if (act) begin
      if (held_valid_q) begin
        held_valid_d    = 1'b0;
        push_o          = 1'b1;
        entry_o.two_res = 1'b1;
        entry_o.r0_high = held_high_q;
        entry_o.r0_low  = held_low_q;
        if (held_is_hash) begin
          if (in_i.resolved_address == '0) begin
            b_unres = 1'b1;
          end else if ((held_op == OP_VTX_HASH) && vtx_too_many) begin
            bad_hit = 1'b1;
          end else begin
            entry_o.r0_low  = in_i.resolved_address;
            entry_o.r1_high = '0;
            entry_o.r1_low  = '0;
            case (held_op)
              OP_NEST_HASH: begin
                entry_o.r0_high = {OP_BRANCH, 24'h0} | (held_high_q & PUSH_BIT);
                b_nest = 1'b1;
              end
              OP_TEX_HASH: begin
                entry_o.r0_high = {OP_TEXIMG, held_high_q[23:0]};
                b_tex = 1'b1;
              end
              default: begin
                entry_o.r0_high = {OP_VTX, held_high_q[23:0]};
                b_vtx = 1'b1;
              end
            endcase
          end
        end
      end else if (op == OP_END) begin
        end_hit = 1'b1;
        push_o  = 1'b1;
      end else if (is_two_word(op)) begin
        if (in_i.list_last) begin
          bad_hit = 1'b1;
          push_o  = 1'b1;
        end else begin
          held_load    = 1'b1;
          held_valid_d = 1'b1;
        end
      end else if (is_cull) begin
        push_o = 1'b1;
        if (!cull_idx_ok) begin
          bad_hit = 1'b1;
        end else if (in_i.resolved_address == '0) begin
          b_unres = 1'b1;
        end else begin
          b_cull          = 1'b1;
          entry_o.r0_high = {OP_BRANCH, 24'h0} | (in_i.word_high & PUSH_BIT);
          entry_o.r0_low  = in_i.resolved_address;
        end
      end else begin
        push_o = 1'b1;
      end
    end
    tot_d.unresolved = sat_inc(tot_q.unresolved, b_unres);
    tot_d.nested     = sat_inc(tot_q.nested, b_nest);
    tot_d.texture    = sat_inc(tot_q.texture, b_tex);
    tot_d.vertex     = sat_inc(tot_q.vertex, b_vtx);
    tot_d.cull       = sat_inc(tot_q.cull, b_cull);
    entry_o.status   = state_d;
    entry_o.totals   = tot_d;
  end

  // list state
  always_comb begin
    state_d = state_q;
    if (act) begin
      if (end_hit) begin
        state_d = ST_END;
      end else if (bad_hit || in_i.list_last) begin
        state_d = ST_BAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SCAN;
      held_valid_q <= 1'b0;
      tot_q        <= '0;
    end else begin
      state_q      <= state_d;
      held_valid_q <= held_valid_d;
      tot_q        <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_load) begin
      held_high_q <= in_i.word_high;
      held_low_q  <= in_i.word_low;
    end
  end

  a_held_only_scanning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (state_q == ST_SCAN))
    else $error("first half of a command held after the list finished");

  a_finish_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |=> (state_q == $past(state_q)))
    else $error("list state left a finished state");

endmodule

// ===== rtl/core/cmdp_fifo.sv =====
module cmdp_fifo import cmdp_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

// ===== rtl/core/cmdp_back.sv =====
module cmdp_back import cmdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  entry_t    head_i,
  output logic      pop_o,
  cmdp_out_if.source out_o
);

  logic        valid_q, valid_d;
  logic        sel_q, sel_d;
  logic        load, is_last;
  logic [31:0] high_q, low_q;
  logic        last_q;
  list_state_e status_q;
  totals_t     totals_q;

  // output register refills when empty or being drained
  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign is_last = !head_i.two_res || sel_q;
  assign pop_o   = load && is_last;

  always_comb begin
    valid_d = valid_q && !out_o.ready;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      high_q   <= sel_q ? head_i.r1_high : head_i.r0_high;
      low_q    <= sel_q ? head_i.r1_low  : head_i.r0_low;
      last_q   <= is_last;
      status_q <= head_i.status;
      totals_q <= head_i.totals;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.out_high         = high_q;
  assign out_o.out_low          = low_q;
  assign out_o.run_last         = last_q;
  assign out_o.status           = status_q;
  assign out_o.unresolved_count = totals_q.unresolved;
  assign out_o.nested_count     = totals_q.nested;
  assign out_o.texture_count    = totals_q.texture;
  assign out_o.vertex_count     = totals_q.vertex;
  assign out_o.cull_count       = totals_q.cull;

endmodule

// ===== rtl/core/display_command_patcher.sv =====
// display command patcher: takes one 64-bit display-list command per input
// transaction and rewrites texture, vertex and nested-list hash references, and
// cull-list index commands, into pointer commands using the resolver answer that
// travels with the transaction. A new command is taken every cycle while the
// internal queue has room; two-word commands give nothing for their first half
// and two results for their payload, so each transaction gives one result on
// average. The output port delivers one result per cycle while the receiver
// is ready; the results of an accepted transaction pass through the internal
// queue and the output register. Once the list has ended (status 1) or turned
// malformed (status 2), further commands are taken and dropped until reset.
module display_command_patcher import cmdp_pkg::*; #(
  parameter int unsigned VERTEX_BYTES = VertexBytesDefault,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmdp_in_if.sink    in_i,
  cmdp_out_if.source out_o
);

  // front: decode, hold first halves, patch, count and track list state
  // queue: absorbs output stalls so the front keeps taking transactions
  // back: unpacks each queue entry into one or two results through an
  //       output register
  logic   push, pop, full, empty;
  entry_t entry, head;

  cmdp_front #(
    .VERTEX_BYTES (VERTEX_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  cmdp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  cmdp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
